// ----- hdl/rdcl_pkg.sv -----
// Package for the radio duty-cycle limiter: field widths, register defaults,
// FSM state and register index enums, divider request struct.
// No dependencies.
package rdcl_pkg;

    localparam int TIME_WIDTH_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int PERIOD_W  = 32;
    localparam int DUTY_W    = 16;
    localparam int AIRTIME_W = 24;
    localparam int TOTAL_W   = 32;
    localparam int WAIT_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int BUDGET_W  = DUTY_W + PERIOD_W;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(3600000);
    localparam logic [DUTY_W-1:0]   DUTY_RST   = DUTY_W'(655);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_PERIOD = 1'b0,
        CFG_DUTY_LIMIT    = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ACT_QUERY  = 1'b0,
        ACT_RECORD = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROLL,
        ST_EVAL,
        ST_CMP,
        ST_SAT,
        ST_DIV,
        ST_DONE
    } t_state;

    // request to the iterative divider
    typedef struct packed {
        logic              start;
        logic [DUTY_W-1:0] rem_init;   // upper part of dividend, below divisor
        logic [WAIT_W-1:0] dividend;   // lower part, fed one bit per step
        logic [DUTY_W-1:0] divisor;
    } t_div_req;

endpackage

// ----- hdl/rdcl_in_if.sv -----
// Input item channel of the duty-cycle limiter: valid/ready plus payload.
// Depends on rdcl_pkg.
interface rdcl_in_if #(
    parameter int TIME_WIDTH = rdcl_pkg::TIME_WIDTH_DEF
);
    import rdcl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [AIRTIME_W-1:0] airtime;
    logic [TIME_WIDTH-1:0] now_time;

    modport source (output valid, output action, output airtime, output now_time,
                    input ready);
    modport sink   (input valid, input action, input airtime, input now_time,
                    output ready);
endinterface

// ----- hdl/rdcl_out_if.sv -----
// Result item channel of the duty-cycle limiter: valid/ready plus payload.
// Depends on rdcl_pkg.
interface rdcl_out_if;
    import rdcl_pkg::*;

    logic              valid;
    logic              ready;
    logic              allowed;
    logic [WAIT_W-1:0] wait_ticks;

    modport source (output valid, output allowed, output wait_ticks, input ready);
    modport sink   (input valid, input allowed, input wait_ticks, output ready);
endinterface

// ----- hdl/rdcl_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rdcl_pkg.
module rdcl_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rdcl_pkg::t_div_req         i_req,
    output logic [rdcl_pkg::WAIT_W-1:0] o_quotient,
    output logic                       o_done
);
    import rdcl_pkg::*;

    localparam int CNT_W = $clog2(WAIT_W + 1);

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_done, n_done;
    logic [DUTY_W-1:0] r_rem, n_rem;
    logic [WAIT_W-1:0] r_quo, n_quo;
    logic [DUTY_W-1:0] r_dvs, n_dvs;
    logic [DUTY_W:0]   trial;
    logic              fits;

    always_comb begin
        trial  = {r_rem, r_quo[WAIT_W-1]};
        fits   = trial >= {1'b0, r_dvs};
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_cnt = CNT_W'(WAIT_W);
            n_rem = i_req.rem_init;
            n_quo = i_req.dividend;
            n_dvs = i_req.divisor;
        end else if (r_cnt != '0) begin
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
            n_rem  = fits ? DUTY_W'(trial - {1'b0, r_dvs}) : trial[DUTY_W-1:0];
            n_quo  = {r_quo[WAIT_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ----- hdl/radio_duty_cycle_limiter.sv -----
// Radio duty-cycle limiter, top level: config registers, window state, sequencer.
// Depends on rdcl_pkg, rdcl_in_if, rdcl_out_if and rdcl_div.
//
// One item at a time. An item is taken while the sequencer is idle, even if the
// previous result still sits unclaimed in the output register. A record, or a
// query that fits the budget, passes the roll, evaluate, compare and done
// states on its way to the result register; a refused query also passes the
// saturation state, and the divide state when the wait has to be divided out,
// because the wait is formed by a restoring divider that produces one of its 32
// quotient bits per cycle and then flags completion. The sequencer returns to
// idle as the result register loads, and the next item is taken from idle. A
// finished item holds in its last state while the output register is full and
// not being drained. The budget is duty_limit * window_period, formed by one
// 16x32 multiply per item, and compared exactly against the airtime sum shifted
// up by FRACTION_BITS. A wait that would exceed 32 bits (including any refusal
// with duty_limit zero) is detected before the divide and saturates.
// Configuration writes are taken at any time and must only happen while idle.
module radio_duty_cycle_limiter #(
    parameter int TIME_WIDTH    = rdcl_pkg::TIME_WIDTH_DEF,
    parameter int FRACTION_BITS = rdcl_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rdcl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rdcl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rdcl_in_if.sink                         i_in,
    rdcl_out_if.source                      o_out
);
    import rdcl_pkg::*;

    // widths of the budget arithmetic
    localparam int AMT_W   = TOTAL_W + 1;
    localparam int SHIFT_W = AMT_W + FRACTION_BITS;
    localparam int CMP_W   = (SHIFT_W > BUDGET_W) ? SHIFT_W : BUDGET_W;
    localparam int HI_W    = CMP_W - WAIT_W;
    localparam int EL_W    = (TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W;

    t_state r_state, n_state;

    // configuration
    logic [PERIOD_W-1:0] r_period;
    logic [DUTY_W-1:0]   r_duty;

    // window state
    logic [TIME_WIDTH-1:0] r_begin;
    logic [TOTAL_W-1:0]    r_total;

    // captured item and working values
    logic                  r_act;
    logic [AIRTIME_W-1:0]  r_air;
    logic [TIME_WIDTH-1:0] r_now;
    logic [BUDGET_W-1:0]   r_budget;
    logic [AMT_W-1:0]      r_amount;
    logic [CMP_W-1:0]      r_excess;
    logic                  r_res_allowed;
    logic [WAIT_W-1:0]     r_res_wait;

    // output register
    logic              r_out_valid;
    logic              r_out_allowed;
    logic [WAIT_W-1:0] r_out_wait;

    logic [TIME_WIDTH-1:0] elapsed;
    logic                  restart;
    logic [AMT_W-1:0]      sum;
    logic [TOTAL_W-1:0]    sum_sat;
    logic [CMP_W-1:0]      amount_sh;
    logic                  fits;
    logic [HI_W-1:0]       excess_hi;
    logic                  wait_sat;
    logic                  out_free;
    logic                  accept;

    t_div_req          div_req;
    logic [WAIT_W-1:0] div_quo;
    logic              div_done;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // window roll: unsigned wrapping elapsed time against the period
    assign elapsed = r_now - r_begin;
    assign restart = EL_W'(elapsed) > EL_W'(r_period);

    // saturating airtime sum
    assign sum     = AMT_W'(r_total) + AMT_W'(r_air);
    assign sum_sat = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

    // exact budget compare
    assign amount_sh = CMP_W'(r_amount) << FRACTION_BITS;
    assign fits      = amount_sh <= CMP_W'(r_budget);

    // quotient exceeds 32 bits exactly when the upper dividend part reaches the divisor
    assign excess_hi = r_excess[CMP_W-1:WAIT_W];
    assign wait_sat  = excess_hi >= HI_W'(r_duty);

    always_comb begin
        div_req.start    = (r_state == ST_SAT) && !wait_sat;
        div_req.rem_init = excess_hi[DUTY_W-1:0];
        div_req.dividend = r_excess[WAIT_W-1:0];
        div_req.divisor  = r_duty;
    end

    rdcl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_ROLL;
                end
            end
            ST_ROLL: n_state = ST_EVAL;
            ST_EVAL: n_state = ST_CMP;
            ST_CMP: begin
                if (fits || r_act == ACT_RECORD) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                n_state = wait_sat ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == ST_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_duty   <= DUTY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_DUTY_LIMIT:    r_duty   <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin <= '0;
            r_total <= '0;
        end else if (r_state == ST_ROLL && restart) begin
            r_begin <= r_now;
            r_total <= '0;
        end else if (r_state == ST_EVAL && r_act == ACT_RECORD) begin
            r_total <= sum_sat;
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_act <= i_in.action;
                    r_air <= i_in.airtime;
                    r_now <= i_in.now_time;
                end
            end
            ST_ROLL: begin
                r_budget <= BUDGET_W'(r_duty) * BUDGET_W'(r_period);
            end
            ST_EVAL: begin
                // a record compares the new saturated total, a query the raw sum
                r_amount <= (r_act == ACT_RECORD) ? AMT_W'(sum_sat) : sum;
            end
            ST_CMP: begin
                r_excess      <= amount_sh - CMP_W'(r_budget);
                r_res_allowed <= fits;
                r_res_wait    <= '0;
            end
            ST_SAT: begin
                if (wait_sat) begin
                    r_res_wait <= '1;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    r_res_wait <= div_quo;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_allowed <= r_res_allowed;
            r_out_wait    <= r_res_wait;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.allowed    = r_out_allowed;
    assign o_out.wait_ticks = r_out_wait;

    // a finished item always lands in the output register and frees the sequencer
    a_done_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished item not delivered to output register");

    // an allowed result never carries a wait
    a_allowed_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.allowed) |-> (o_out.wait_ticks == '0))
        else $error("allowed result with nonzero wait");

    // a record never lowers the airtime total
    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL && r_act == ACT_RECORD) |=> (r_total >= $past(r_total)))
        else $error("record decreased airtime total");

    // divider finishes only while the sequencer waits on it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider done outside divide state");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for radio_duty_cycle_limiter: directed and random
// query/record items with random idling on both channels, checked against a predictor.
// Depends on rdcl_pkg, rdcl_in_if, rdcl_out_if and the limiter RTL.
module tb;
    import rdcl_pkg::*;

    localparam int FRAC = FRACTION_BITS_DEF;

    // One expected result item
    typedef struct packed {
        logic              allowed;
        logic [WAIT_W-1:0] wait_ticks;
    } t_verdict;

    // Airtime budget predictor plus the queue of verdicts still owed by the block
    class airtime_budget_model;
        logic [PERIOD_W-1:0] period;
        logic [DUTY_W-1:0]   duty;
        logic [31:0]         win_begin;
        logic [TOTAL_W-1:0]  total;
        t_verdict            owed[$];
        int                  errors;

        function new();
            period    = PERIOD_RST;
            duty      = DUTY_RST;
            win_begin = '0;
            total     = '0;
            errors    = 0;
        endfunction

        function void set_regs(logic [PERIOD_W-1:0] p, logic [DUTY_W-1:0] d);
            period = p;
            duty   = d;
        endfunction

        // budget scaled up by 2^FRAC, exact
        function logic [63:0] scaled_budget();
            return 64'(duty) * 64'(period);
        endfunction

        function int owed_count();
            return owed.size();
        endfunction

        // Called once per accepted input item
        function void note_item(t_action act, logic [AIRTIME_W-1:0] air, logic [31:0] now);
            logic [31:0] elapsed;
            logic [63:0] want;
            logic [63:0] excess;
            logic [63:0] quot;
            t_verdict    v;
            elapsed = now - win_begin;
            // window restarts only on strictly more than one period
            if (elapsed > period) begin
                win_begin = now;
                total     = '0;
            end
            want         = 64'(total) + 64'(air);
            v.wait_ticks = '0;
            if (act == ACT_QUERY) begin
                if ((want << FRAC) <= scaled_budget()) begin
                    v.allowed = 1'b1;
                end else begin
                    v.allowed = 1'b0;
                    if (duty == '0) begin
                        v.wait_ticks = '1;
                    end else begin
                        excess = (want << FRAC) - scaled_budget();
                        quot   = excess / 64'(duty);
                        v.wait_ticks = (quot > 64'hFFFF_FFFF) ? '1 : quot[WAIT_W-1:0];
                    end
                end
            end else begin
                total     = (want > 64'hFFFF_FFFF) ? '1 : want[TOTAL_W-1:0];
                v.allowed = ((64'(total) << FRAC) <= scaled_budget());
            end
            owed.push_back(v);
        endfunction

        // Called once per accepted result item
        function void check_result(logic allowed, logic [WAIT_W-1:0] wait_ticks);
            t_verdict v;
            if (owed.size() == 0) begin
                $error("result with nothing pending: allowed %0d wait_ticks %0h",
                       allowed, wait_ticks);
                errors++;
                return;
            end
            v = owed.pop_front();
            if (allowed !== v.allowed) begin
                $error("allowed mismatch: expected %0d actual %0d", v.allowed, allowed);
                errors++;
            end
            if (wait_ticks !== v.wait_ticks) begin
                $error("wait_ticks mismatch: expected %0h actual %0h",
                       v.wait_ticks, wait_ticks);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    rdcl_in_if #(.TIME_WIDTH(TIME_WIDTH_DEF)) in_ch ();
    rdcl_out_if                               out_ch ();

    radio_duty_cycle_limiter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    airtime_budget_model sb;

    int          src_streak;    // items left in a no-idle run, sender side
    int          sink_streak;   // same for the receiver side
    logic [31:0] cur_now;       // timestamp of the last item sent

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Idle cycles before the next item; now and then a run of back-to-back items
    function automatic int draw_gap(inout int streak);
        if (streak > 0) begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            streak = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    // Send one item and wait for its handshake. valid stays high when the next
    // item follows with no gap, so it is never lowered and raised in one step.
    task automatic send_item(input t_action act, input logic [AIRTIME_W-1:0] air,
                             input logic [31:0] now);
        int gap;
        gap = draw_gap(src_streak);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.action   <= act;
        in_ch.airtime  <= air;
        in_ch.now_time <= now;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_item(act, air, now);
        cur_now = now;
    endtask

    // Random item shaped around the current budget and window
    task automatic send_random_item();
        logic [63:0]          spendable;
        logic [63:0]          rem;
        logic [31:0]          cap;
        logic [31:0]          step;
        logic [31:0]          nowv;
        logic [AIRTIME_W-1:0] air;
        t_action              act;
        int                   pick;
        spendable = sb.scaled_budget() >> FRAC;
        act  = $urandom_range(0, 1) ? ACT_RECORD : ACT_QUERY;
        pick = $urandom_range(0, 9);
        if (pick <= 4) begin
            // small bites, so records pile up toward the budget
            cap = ((spendable >> 2) > 64'hFF_FFFF) ? 32'hFF_FFFF : 32'(spendable >> 2);
            air = AIRTIME_W'($urandom_range(0, cap));
        end else if (pick <= 6) begin
            // right at the remaining budget, within a couple of ticks
            rem = (spendable > 64'(sb.total)) ? spendable - 64'(sb.total) : 64'd0;
            if (rem <= 64'hFF_FFFD) begin
                rem = rem + 64'($urandom_range(0, 4));
                air = (rem >= 2) ? AIRTIME_W'(rem - 2) : '0;
            end else begin
                air = AIRTIME_W'($urandom);
            end
        end else if (pick <= 8) begin
            air = AIRTIME_W'($urandom);
        end else begin
            air = $urandom_range(0, 1) ? '1 : '0;
        end

        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
            step = (sb.period == '0) ? 32'd2 : (sb.period >> 2) + 32'd1;
            nowv = cur_now + $urandom_range(0, step);
        end else if (pick == 6) begin
            // on the window edge or one past it
            nowv = sb.win_begin + sb.period + $urandom_range(0, 1);
        end else if (pick == 7) begin
            nowv = $urandom;
        end else begin
            nowv = cur_now;
        end
        send_item(act, air, nowv);
    endtask

    task automatic send_random_items(input int count);
        repeat (count) send_random_item();
    endtask

    // Drop valid and wait for every owed result before touching registers
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed_count() != 0) @(posedge i_clk);
    endtask

    // Both registers, back to back; block is idle here
    task automatic write_regs(input logic [PERIOD_W-1:0] p, input logic [DUTY_W-1:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WINDOW_PERIOD;
        cfg_data <= CFG_DATA_W'(p);
        @(posedge i_clk);
        cfg_idx  <= CFG_DUTY_LIMIT;
        cfg_data <= CFG_DATA_W'(d);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sb.set_regs(p, d);
    endtask

    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = draw_gap(sink_streak);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            sb.check_result(out_ch.allowed, out_ch.wait_ticks);
        end
    end

    initial begin : stimulus
        logic [31:0] t;
        int          ph;
        sb          = new();
        src_streak  = 0;
        sink_streak = 0;
        cur_now     = '0;
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_WINDOW_PERIOD;
        cfg_data       <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.action   <= ACT_QUERY;
        in_ch.airtime  <= '0;
        in_ch.now_time <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: budget is just under 35981 ticks per 3600000
        send_item(ACT_QUERY,  24'd0,       32'd0);
        send_item(ACT_QUERY,  24'hFF_FFFF, 32'd0);          // refused, large wait
        send_item(ACT_RECORD, 24'd30000,   32'd5);
        send_item(ACT_QUERY,  24'd5980,    32'd10);         // exactly fits
        send_item(ACT_QUERY,  24'd5981,    32'd10);         // one tick over, divided wait
        send_item(ACT_QUERY,  24'd0,       32'd3600000);    // elapsed equals period: kept
        send_item(ACT_RECORD, 24'hFF_FFFF, 32'd3600000);    // record past the budget
        send_item(ACT_QUERY,  24'd1,       32'd3600000);
        send_item(ACT_QUERY,  24'd0,       32'd3600001);    // one past: window restarts
        send_item(ACT_RECORD, 24'd35980,   32'd3600002);    // record that just fits
        send_item(ACT_RECORD, 24'd1,       32'd3600003);
        send_item(ACT_QUERY,  24'd0,       32'hFFFF_FFFF);  // far ahead: restart
        send_item(ACT_QUERY,  24'd0,       32'd5);          // timestamp wrap, same window
        send_item(ACT_QUERY,  24'hFF_FFFF, 32'h8000_0000);
        send_random_items(120);
        drain();

        // Zero budget and zero period
        write_regs('0, '0);
        t = sb.win_begin;
        send_item(ACT_QUERY,  24'd0,       t);              // nothing wanted: allowed
        send_item(ACT_QUERY,  24'd1,       t);              // saturated wait
        send_item(ACT_RECORD, 24'd5,       t);
        send_item(ACT_QUERY,  24'd0,       t);
        send_item(ACT_QUERY,  24'd0,       t + 32'd1);      // any change restarts
        send_item(ACT_QUERY,  24'hFF_FFFF, t + 32'd1);
        send_random_items(120);
        drain();

        // Largest period and fraction; long run of records saturates the total
        write_regs('1, '1);
        t = sb.win_begin;
        send_item(ACT_QUERY, 24'hFF_FFFF, t);
        send_item(ACT_QUERY, 24'd0,       t + 32'hFFFF_FFFF);
        t = cur_now;
        repeat (280) send_item(ACT_RECORD, AIRTIME_W'($urandom_range(24'hF0_0000, 24'hFF_FFFF)), t);
        repeat (4) send_item(ACT_QUERY, AIRTIME_W'($urandom), t);
        send_random_items(120);
        drain();

        // Smallest nonzero settings: budget rounds to nothing
        write_regs(32'd1, 16'd1);
        t = sb.win_begin;
        send_item(ACT_QUERY,  24'd0,       t + 32'd2);
        send_item(ACT_QUERY,  24'd1,       t + 32'd2);
        send_item(ACT_QUERY,  24'hFF_FFFF, t + 32'd2);
        send_item(ACT_RECORD, 24'd1,       t + 32'd2);
        send_item(ACT_QUERY,  24'd0,       t + 32'd3);
        send_item(ACT_QUERY,  24'd0,       t + 32'd4);
        send_random_items(120);
        drain();

        // Random settings, mostly short periods so windows roll often
        for (ph = 0; ph < 4; ph++) begin
            write_regs(($urandom_range(0, 3) == 0) ? PERIOD_W'($urandom)
                                                   : PERIOD_W'($urandom_range(1, 20000)),
                       DUTY_W'($urandom_range(1, 65535)));
            send_random_items(120);
            drain();
        end

        // idle tail before the final check
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_count() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop, several times the slowest legal run
    initial begin : watchdog
        #(12 * 400000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/rdcl_pkg.sv
hdl/rdcl_in_if.sv
hdl/rdcl_out_if.sv
hdl/rdcl_div.sv
hdl/radio_duty_cycle_limiter.sv
tb/sv/tb.sv
